// File: design/scpo_pkg.sv
// ----------------------------------------------------------------------------
// scpo_pkg: shared widths and types for the segment closest point pipeline
// Coordinate widths, intermediate widths and the sideband records that
// travel next to the square root and divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package scpo_pkg;

   localparam int COORD_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int INSET_W    = 15;
   localparam int OUT_W      = 17;

   // difference of two coordinates
   localparam int D_W        = COORD_BITS + 1;
   // squared length, always even so the root takes whole digit pairs
   localparam int SQ_W       = 2 * D_W;
   localparam int LEN_W      = D_W;
   localparam int DOT_W      = 2 * D_W + 1;
   localparam int PROD_W     = D_W + LEN_W + 1;
   localparam int NUM_W      = DOT_W + 1;
   localparam int DEN_W      = LEN_W + 1;
   localparam int SQRT_STEPS = SQ_W / 2;

   // carried alongside the square root
   typedef struct packed {
      logic signed [DOT_W-1:0]      dot;
      logic signed [D_W-1:0]        dx;
      logic signed [D_W-1:0]        dy;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic [INSET_W-1:0]           inset;
   } geom_type;

   // carried alongside the projection divide
   typedef struct packed {
      logic signed [D_W-1:0]        dx;
      logic signed [D_W-1:0]        dy;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic [INSET_W-1:0]           inset;
      logic [LEN_W-1:0]             len;
      logic                         neg;
   } proj_type;

   localparam int SIDE_W = $bits(proj_type);

   // carried alongside the final rounding divides
   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic                         negx;
      logic                         negy;
      logic                         short_seg;
   } tail_type;

   localparam int TAIL_W = $bits(tail_type);

endpackage

`default_nettype wire

// File: design/scpo_front.sv
// ----------------------------------------------------------------------------
// scpo_front: differences, products and sums
// Three stages: B-A and C-A, the four products, then |B-A|^2 and the dot
// product.
// ----------------------------------------------------------------------------
`default_nettype none

module scpo_front
   import scpo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [FIELD_W-1:0]    start_x,
   input  wire logic [FIELD_W-1:0]    start_y,
   input  wire logic [FIELD_W-1:0]    end_x,
   input  wire logic [FIELD_W-1:0]    end_y,
   input  wire logic [FIELD_W-1:0]    probe_x,
   input  wire logic [FIELD_W-1:0]    probe_y,
   input  wire logic [INSET_W-1:0]    inset,
   output logic                       out_valid,
   output logic [SQ_W-1:0]            sq,
   output geom_type                   geom
);

   logic [2:0] valid_ff;

   logic signed [COORD_BITS-1:0] ax1_in, ay1_in, ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic signed [D_W-1:0] dx1_in, dy1_in, vx1_in, vy1_in;
   logic signed [D_W-1:0] dx1_ff, dy1_ff, vx1_ff, vy1_ff, dx2_ff, dy2_ff;
   logic [INSET_W-1:0] inset1_ff, inset2_ff;
   logic signed [2*D_W-1:0] pxx_ff, pyy_ff, pxv_ff, pyv_ff;
   logic [SQ_W-1:0] sq_in, sq_ff;
   logic signed [DOT_W-1:0] dot_in;
   geom_type geom_ff;

   // stage 1: differences
   always_comb begin
      ax1_in = start_x[COORD_BITS-1:0];
      ay1_in = start_y[COORD_BITS-1:0];
      dx1_in = D_W'($signed(end_x[COORD_BITS-1:0]))   - D_W'(ax1_in);
      dy1_in = D_W'($signed(end_y[COORD_BITS-1:0]))   - D_W'(ay1_in);
      vx1_in = D_W'($signed(probe_x[COORD_BITS-1:0])) - D_W'(ax1_in);
      vy1_in = D_W'($signed(probe_y[COORD_BITS-1:0])) - D_W'(ay1_in);
   end

   // stage 3 sums
   always_comb begin
      sq_in  = SQ_W'(unsigned'(pxx_ff)) + SQ_W'(unsigned'(pyy_ff));
      dot_in = DOT_W'(pxv_ff) + DOT_W'(pyv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff    <= ax1_in;
         ay1_ff    <= ay1_in;
         dx1_ff    <= dx1_in;
         dy1_ff    <= dy1_in;
         vx1_ff    <= vx1_in;
         vy1_ff    <= vy1_in;
         inset1_ff <= inset;
         // stage 2: products
         pxx_ff    <= dx1_ff * dx1_ff;
         pyy_ff    <= dy1_ff * dy1_ff;
         pxv_ff    <= dx1_ff * vx1_ff;
         pyv_ff    <= dy1_ff * vy1_ff;
         dx2_ff    <= dx1_ff;
         dy2_ff    <= dy1_ff;
         ax2_ff    <= ax1_ff;
         ay2_ff    <= ay1_ff;
         inset2_ff <= inset1_ff;
         // stage 3: sums
         sq_ff         <= sq_in;
         geom_ff.dot   <= dot_in;
         geom_ff.dx    <= dx2_ff;
         geom_ff.dy    <= dy2_ff;
         geom_ff.ax    <= ax2_ff;
         geom_ff.ay    <= ay2_ff;
         geom_ff.inset <= inset2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign sq        = sq_ff;
   assign geom      = geom_ff;

endmodule

`default_nettype wire

// File: design/scpo_isqrt.sv
// ----------------------------------------------------------------------------
// scpo_isqrt: pipelined floor square root
// One result bit per stage, two radicand bits brought down each time.
// ----------------------------------------------------------------------------
`default_nettype none

module scpo_isqrt
   import scpo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [SQ_W-1:0]       sq,
   input  wire geom_type              in_geom,
   output logic                       out_valid,
   output logic [LEN_W-1:0]           len,
   output geom_type                   out_geom
);

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [LEN_W:0]        rem_ff  [SQRT_STEPS];
   logic [LEN_W-1:0]      root_ff [SQRT_STEPS];
   logic [SQ_W-1:0]       rad_ff  [SQRT_STEPS];
   geom_type              geom_ff [SQRT_STEPS];

   logic [LEN_W:0]        st_rem  [SQRT_STEPS];
   logic [LEN_W-1:0]      st_root [SQRT_STEPS];
   logic [SQ_W-1:0]       st_rad  [SQRT_STEPS];
   geom_type              st_geom [SQRT_STEPS];
   logic [SQRT_STEPS-1:0] st_valid;

   assign st_rem[0]   = '0;
   assign st_root[0]  = '0;
   assign st_rad[0]   = sq;
   assign st_geom[0]  = in_geom;
   assign st_valid[0] = in_valid;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      logic [LEN_W+2:0] cur;
      logic [LEN_W+2:0] trial;
      logic [LEN_W+2:0] diff;
      logic             take;

      // one digit of the root
      always_comb begin
         cur   = {st_rem[g], st_rad[g][SQ_W-1 -: 2]};
         trial = {1'b0, st_root[g], 2'b01};
         diff  = cur - trial;
         take  = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= st_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= take ? diff[LEN_W:0] : cur[LEN_W:0];
            root_ff[g] <= {st_root[g][LEN_W-2:0], take};
            rad_ff[g]  <= {st_rad[g][SQ_W-3:0], 2'b00};
            geom_ff[g] <= st_geom[g];
         end
      end

      if (g + 1 < SQRT_STEPS) begin : g_link
         assign st_rem[g+1]   = rem_ff[g];
         assign st_root[g+1]  = root_ff[g];
         assign st_rad[g+1]   = rad_ff[g];
         assign st_geom[g+1]  = geom_ff[g];
         assign st_valid[g+1] = valid_ff[g];
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign len       = root_ff[SQRT_STEPS-1];
   assign out_geom  = geom_ff[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: design/scpo_div.sv
// ----------------------------------------------------------------------------
// scpo_div: pipelined unsigned restoring divider
// One quotient bit per stage; the quotient shifts into the dividend word.
// ----------------------------------------------------------------------------
`default_nettype none

module scpo_div
   import scpo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [NUM_W-1:0]      num,
   input  wire logic [DEN_W-1:0]      den,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [NUM_W-1:0]           quo,
   output logic [SIDE_W-1:0]          out_side
);

   logic [NUM_W-1:0]  valid_ff;
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   logic [DEN_W-1:0]  st_rem  [NUM_W];
   logic [NUM_W-1:0]  st_num  [NUM_W];
   logic [DEN_W-1:0]  st_den  [NUM_W];
   logic [SIDE_W-1:0] st_side [NUM_W];
   logic [NUM_W-1:0]  st_valid;

   assign st_rem[0]   = '0;
   assign st_num[0]   = num;
   assign st_den[0]   = den;
   assign st_side[0]  = in_side;
   assign st_valid[0] = in_valid;

   for (genvar g = 0; g < NUM_W; g++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;

      // one trial subtract
      always_comb begin
         trial = {st_rem[g], st_num[g][NUM_W-1]};
         diff  = trial - {1'b0, st_den[g]};
         take  = (trial >= {1'b0, st_den[g]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= st_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_ff[g]  <= {st_num[g][NUM_W-2:0], take};
            den_ff[g]  <= st_den[g];
            side_ff[g] <= st_side[g];
         end
      end

      if (g + 1 < NUM_W) begin : g_link
         assign st_rem[g+1]   = rem_ff[g];
         assign st_num[g+1]   = num_ff[g];
         assign st_den[g+1]   = den_ff[g];
         assign st_side[g+1]  = side_ff[g];
         assign st_valid[g+1] = valid_ff[g];
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign quo       = num_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

`default_nettype wire

// File: design/scpo_shape.sv
// ----------------------------------------------------------------------------
// scpo_shape: projection clamping and rounding setup
// Three stages: inset clamp, offset products, then the rounding numerators
// (2*|d*p| + len) over the shared denominator 2*len.
// ----------------------------------------------------------------------------
`default_nettype none

module scpo_shape
   import scpo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [NUM_W-1:0]      quo,
   input  wire proj_type              in_proj,
   output logic                       out_valid,
   output logic [NUM_W-1:0]           num_x,
   output logic [NUM_W-1:0]           num_y,
   output logic [DEN_W-1:0]           den,
   output tail_type                   tail
);

   logic [2:0] valid_ff;

   logic [LEN_W-1:0] pc, hi, p1_in;
   logic [LEN_W:0]   t;
   logic             use_inset, wide;

   logic [LEN_W-1:0] p1_ff, len1_ff, len2_ff;
   logic signed [D_W-1:0] dx1_ff, dy1_ff;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic signed [PROD_W-1:0] px2_ff, py2_ff;
   logic [PROD_W-2:0] magx, magy;
   logic negx, negy;
   logic [NUM_W-1:0] numx_ff, numy_ff;
   logic [DEN_W-1:0] den_ff;
   tail_type tail_ff;

   // stage 1: clamp to the segment, then apply the inset
   always_comb begin
      if (in_proj.neg) begin
         pc = '0;
      end else if (quo > NUM_W'(in_proj.len)) begin
         pc = in_proj.len;
      end else begin
         pc = quo[LEN_W-1:0];
      end
      use_inset = (in_proj.inset != '0);
      wide      = (LEN_W'({in_proj.inset, 1'b0}) < in_proj.len);
      t         = (LEN_W+1)'(pc) + (LEN_W+1)'(in_proj.inset);
      hi        = in_proj.len - LEN_W'(in_proj.inset);
      if (use_inset && wide) begin
         p1_in = (t > (LEN_W+1)'(hi)) ? hi : t[LEN_W-1:0];
      end else if (use_inset) begin
         p1_in = in_proj.len >> 1;
      end else begin
         p1_in = pc;
      end
   end

   // stage 3: magnitudes and rounding numerators
   always_comb begin
      negx = px2_ff[PROD_W-1];
      negy = py2_ff[PROD_W-1];
      magx = negx ? (PROD_W-1)'(-px2_ff) : px2_ff[PROD_W-2:0];
      magy = negy ? (PROD_W-1)'(-py2_ff) : py2_ff[PROD_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p1_in;
         len1_ff <= in_proj.len;
         dx1_ff  <= in_proj.dx;
         dy1_ff  <= in_proj.dy;
         ax1_ff  <= in_proj.ax;
         ay1_ff  <= in_proj.ay;
         // stage 2: d * proj
         px2_ff  <= dx1_ff * $signed({1'b0, p1_ff});
         py2_ff  <= dy1_ff * $signed({1'b0, p1_ff});
         len2_ff <= len1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         // stage 3
         numx_ff           <= {1'b0, magx, 1'b0} + NUM_W'(len2_ff);
         numy_ff           <= {1'b0, magy, 1'b0} + NUM_W'(len2_ff);
         den_ff            <= {len2_ff, 1'b0};
         tail_ff.ax        <= ax2_ff;
         tail_ff.ay        <= ay2_ff;
         tail_ff.negx      <= negx;
         tail_ff.negy      <= negy;
         tail_ff.short_seg <= (len2_ff <= LEN_W'(1));
      end
   end

   assign out_valid = valid_ff[2];
   assign num_x     = numx_ff;
   assign num_y     = numy_ff;
   assign den       = den_ff;
   assign tail      = tail_ff;

endmodule

`default_nettype wire

// File: design/segment_closest_point_offset.sv
// ----------------------------------------------------------------------------
// segment_closest_point_offset: closest point on a segment, with end inset
// Projects the probe onto segment A-B, clamps with the inset and returns
// A + (B-A)*proj/len rounded half away from zero on each axis.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  A, B, probe, inset
//   rsp      out        rsp_valid/rsp_stall  closest x, y
//
// One word enters per cycle while not stalled and passes the stages
// (3 front, 17 square root, 36 projection divide, 3 shaping, 36 rounding
// divide, 1 output register). All stages share one advance enable that
// drops only while a result waits in the output register under stall.
// Reset clears the valid bits of every stage; data registers are not reset.
`default_nettype none

module segment_closest_point_offset
   import scpo_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [FIELD_W-1:0]   req_start_x,
   input  wire logic [FIELD_W-1:0]   req_start_y,
   input  wire logic [FIELD_W-1:0]   req_end_x,
   input  wire logic [FIELD_W-1:0]   req_end_y,
   input  wire logic [FIELD_W-1:0]   req_probe_x,
   input  wire logic [FIELD_W-1:0]   req_probe_y,
   input  wire logic [INSET_W-1:0]   req_inset,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [OUT_W-1:0]          rsp_closest_x,
   output logic [OUT_W-1:0]          rsp_closest_y
);

   logic en;

   logic              fr_valid;
   logic [SQ_W-1:0]   fr_sq;
   geom_type          fr_geom;

   logic              sr_valid;
   logic [LEN_W-1:0]  sr_len;
   geom_type          sr_geom;

   proj_type          pd_side_in;
   logic [NUM_W-1:0]  pd_num;
   logic              pd_valid;
   logic [NUM_W-1:0]  pd_quo;
   logic [SIDE_W-1:0] pd_side;

   logic              sh_valid;
   logic [NUM_W-1:0]  sh_num_x, sh_num_y;
   logic [DEN_W-1:0]  sh_den;
   tail_type          sh_tail;

   logic              fx_valid;
   logic [NUM_W-1:0]  fx_quo, fy_quo;
   logic [SIDE_W-1:0] fx_side;
   tail_type          fx_tail;

   logic [OUT_W-1:0]  qx, qy, ox_in, oy_in;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_closest_x_ff, rsp_closest_y_ff;

   // global advance
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   scpo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .probe_x   (req_probe_x),
      .probe_y   (req_probe_y),
      .inset     (req_inset),
      .out_valid (fr_valid),
      .sq        (fr_sq),
      .geom      (fr_geom)
   );

   scpo_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .sq        (fr_sq),
      .in_geom   (fr_geom),
      .out_valid (sr_valid),
      .len       (sr_len),
      .out_geom  (sr_geom)
   );

   // projection divide operands: |dot| over len
   always_comb begin
      pd_side_in.dx    = sr_geom.dx;
      pd_side_in.dy    = sr_geom.dy;
      pd_side_in.ax    = sr_geom.ax;
      pd_side_in.ay    = sr_geom.ay;
      pd_side_in.inset = sr_geom.inset;
      pd_side_in.len   = sr_len;
      pd_side_in.neg   = sr_geom.dot[DOT_W-1];
      pd_num           = sr_geom.dot[DOT_W-1] ? NUM_W'(-sr_geom.dot)
                                              : NUM_W'(sr_geom.dot);
   end

   scpo_div u_proj_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sr_valid),
      .num       (pd_num),
      .den       ({1'b0, sr_len}),
      .in_side   (pd_side_in),
      .out_valid (pd_valid),
      .quo       (pd_quo),
      .out_side  (pd_side)
   );

   scpo_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pd_valid),
      .quo       (pd_quo),
      .in_proj   (proj_type'(pd_side)),
      .out_valid (sh_valid),
      .num_x     (sh_num_x),
      .num_y     (sh_num_y),
      .den       (sh_den),
      .tail      (sh_tail)
   );

   scpo_div u_round_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sh_valid),
      .num       (sh_num_x),
      .den       (sh_den),
      .in_side   ({{(SIDE_W-TAIL_W){1'b0}}, sh_tail}),
      .out_valid (fx_valid),
      .quo       (fx_quo),
      .out_side  (fx_side)
   );

   scpo_div u_round_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sh_valid),
      .num       (sh_num_y),
      .den       (sh_den),
      .in_side   ('0),
      .out_valid (),
      .quo       (fy_quo),
      .out_side  ()
   );

   // A plus signed rounded offset; short segments give A
   always_comb begin
      fx_tail = tail_type'(fx_side[TAIL_W-1:0]);
      qx      = fx_tail.negx ? OUT_W'(-fx_quo) : fx_quo[OUT_W-1:0];
      qy      = fx_tail.negy ? OUT_W'(-fy_quo) : fy_quo[OUT_W-1:0];
      if (fx_tail.short_seg) begin
         ox_in = OUT_W'(fx_tail.ax);
         oy_in = OUT_W'(fx_tail.ay);
      end else begin
         ox_in = OUT_W'(fx_tail.ax) + qx;
         oy_in = OUT_W'(fx_tail.ay) + qy;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fx_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_closest_x_ff <= ox_in;
         rsp_closest_y_ff <= oy_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_closest_x = rsp_closest_x_ff;
   assign rsp_closest_y = rsp_closest_y_ff;

endmodule

`default_nettype wire
